// ===== design/tbn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbn_pkg
// shared widths and sequencer states of the tangent/bitangent unit
// ----------------------------------------------------------------------------
package tbn_pkg;

   localparam int COORD_W = 32;
   localparam int DELTA_W = COORD_W + 1;
   localparam int PROD_W  = 2 * DELTA_W;
   localparam int ACC_W   = PROD_W + 1;
   localparam int MAG_W   = PROD_W;
   localparam int A_W     = 30;
   localparam int SUM_W   = 2 * A_W + 2;
   localparam int ROOT_W  = SUM_W / 2;
   localparam int NUM_W   = 2 * A_W + 1;
   localparam int QUO_W   = A_W + 1;
   localparam int OUT_W   = 32;
   localparam int MUL_LAST = 13;

   typedef enum logic [12:0] {
      S_IDLE     = 13'b0000000000001,
      S_MUL      = 13'b0000000000010,
      S_ACC      = 13'b0000000000100,
      S_CHECK    = 13'b0000000001000,
      S_LOAD     = 13'b0000000010000,
      S_NORM     = 13'b0000000100000,
      S_SQR      = 13'b0000001000000,
      S_SQA      = 13'b0000010000000,
      S_RT_GO    = 13'b0000100000000,
      S_RT_WAIT  = 13'b0001000000000,
      S_DIV_GO   = 13'b0010000000000,
      S_DIV_WAIT = 13'b0100000000000,
      S_OUT      = 13'b1000000000000
   } state_type;

   typedef struct packed {
      logic start;
      logic done;
   } unit_ctl_type;

endpackage

// ===== design/tbn_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbn_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module tbn_mul (
   input  logic                                clock,
   input  logic signed [tbn_pkg::DELTA_W-1:0]  op_a,
   input  logic signed [tbn_pkg::DELTA_W-1:0]  op_b,
   output logic signed [tbn_pkg::PROD_W-1:0]   prod_ff
);

   logic signed [tbn_pkg::PROD_W-1:0] prod_in;

   assign prod_in = tbn_pkg::PROD_W'(op_a) * tbn_pkg::PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== design/tbn_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbn_sqrt
// iterative integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module tbn_sqrt (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [tbn_pkg::SUM_W-1:0]        rad,
   output logic [tbn_pkg::ROOT_W-1:0]       root,
   output logic                             done_ff
);

   logic                          busy_ff;
   logic [tbn_pkg::SUM_W-1:0]     x_ff;
   logic [tbn_pkg::SUM_W-1:0]     r_ff;
   logic [tbn_pkg::SUM_W-1:0]     bit_ff;
   logic [tbn_pkg::SUM_W:0]       trial;
   logic                          ge;

   assign trial = {1'b0, r_ff} + {1'b0, bit_ff};
   assign ge    = {1'b0, x_ff} >= trial;
   assign root  = r_ff[tbn_pkg::ROOT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && bit_ff[0]) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff   <= rad;
         r_ff   <= '0;
         bit_ff <= tbn_pkg::SUM_W'(1) << (tbn_pkg::SUM_W - 2);
      end else if (busy_ff) begin
         if (ge) begin
            x_ff <= x_ff - trial[tbn_pkg::SUM_W-1:0];
            r_ff <= (r_ff >> 1) + bit_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

endmodule

// ===== design/tbn_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbn_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tbn_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [tbn_pkg::NUM_W-1:0]        num,
   input  logic [tbn_pkg::ROOT_W-1:0]       den,
   output logic [tbn_pkg::QUO_W-1:0]        quo_ff,
   output logic                             done_ff
);

   localparam int CNT_W = $clog2(tbn_pkg::QUO_W);

   logic                          busy_ff;
   logic [CNT_W-1:0]              cnt_ff;
   logic [tbn_pkg::ROOT_W-1:0]    rem_ff;
   logic [tbn_pkg::ROOT_W:0]      trial;
   logic                          ge;

   assign trial = {rem_ff, quo_ff[tbn_pkg::QUO_W-1]};
   assign ge    = trial >= {1'b0, den};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= tbn_pkg::ROOT_W'(num[tbn_pkg::NUM_W-1:tbn_pkg::QUO_W]);
         quo_ff <= num[tbn_pkg::QUO_W-1:0];
         cnt_ff <= CNT_W'(tbn_pkg::QUO_W - 1);
      end else if (busy_ff) begin
         rem_ff <= ge ? tbn_pkg::ROOT_W'(trial - {1'b0, den}) : trial[tbn_pkg::ROOT_W-1:0];
         quo_ff <= {quo_ff[tbn_pkg::QUO_W-2:0], ge};
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

endmodule

// ===== design/triangle_tangent_bitangent.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_tangent_bitangent
// first and second vertex: held in registers, no result
// third vertex: starts the computation of the result, made of 14 multiplier passes, up to 36 one-bit
// normalizing shifts and the squaring of each component per vector, and per vector a
// square root and three divisions; these are skipped when the determinant is zero
// no vertex is taken until the result is loaded into the output register
// synchronous active-high reset clears the vertex count, sequencer and result valid
// ----------------------------------------------------------------------------
module triangle_tangent_bitangent (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [31:0]  req_pos_x,
   input  logic signed [31:0]  req_pos_y,
   input  logic signed [31:0]  req_pos_z,
   input  logic signed [31:0]  req_tex_u,
   input  logic signed [31:0]  req_tex_v,
   input  logic                req_triangle_start,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_tangent_x,
   output logic signed [31:0]  rsp_tangent_y,
   output logic signed [31:0]  rsp_tangent_z,
   output logic signed [31:0]  rsp_bitangent_x,
   output logic signed [31:0]  rsp_bitangent_y,
   output logic signed [31:0]  rsp_bitangent_z,
   output logic                rsp_degenerate
);

   localparam int DW = tbn_pkg::DELTA_W;
   localparam int AW = tbn_pkg::ACC_W;
   localparam int MW = tbn_pkg::MAG_W;
   localparam int QW = tbn_pkg::QUO_W;
   localparam int OW = tbn_pkg::OUT_W;

   tbn_pkg::state_type state_ff, state_in;

   logic                   req_acc;
   logic [1:0]             slot;
   logic [1:0]             cnt_ff;
   logic signed [31:0]     hp_ff [2][3];
   logic signed [31:0]     ht_ff [2][2];
   logic signed [31:0]     pin [3];
   logic signed [DW-1:0]   e1_ff [3];
   logic signed [DW-1:0]   e2_ff [3];
   logic signed [DW-1:0]   du1_ff, dv1_ff, du2_ff, dv2_ff;
   logic [3:0]             mi_ff;
   logic signed [AW-1:0]   acc_ff, prod_x, diff;
   logic signed [AW-1:0]   det_ff;
   logic signed [AW-1:0]   tc_ff [3];
   logic signed [AW-1:0]   bc_ff [3];
   logic                   vsel_ff;
   logic [1:0]             ci_ff;
   logic [MW-1:0]          m_ff [3];
   logic [MW-1:0]          m_or;
   logic                   sg_ff [2][3];
   logic [QW-1:0]          qt_ff [2][3];
   logic [tbn_pkg::SUM_W-1:0] sum_ff;
   logic                   degen_ff;
   logic [tbn_pkg::A_W-1:0] a_sel;
   logic signed [DW-1:0]   op_a, op_b;
   logic signed [tbn_pkg::PROD_W-1:0] prod;
   logic [tbn_pkg::ROOT_W-1:0] root;
   logic [QW-1:0]          quo;
   logic [tbn_pkg::NUM_W-1:0] num;
   tbn_pkg::unit_ctl_type  rt_ctl, dv_ctl;
   logic                   out_load;
   logic                   rsp_valid_ff;
   logic                   rsp_degen_ff;
   logic signed [OW-1:0]   res [2][3];
   logic signed [OW-1:0]   o_ff [2][3];

   assign req_stall = (state_ff != tbn_pkg::S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign slot      = req_triangle_start ? 2'd0 : cnt_ff;
   assign pin[0]    = req_pos_x;
   assign pin[1]    = req_pos_y;
   assign pin[2]    = req_pos_z;

   assign m_or  = m_ff[0] | m_ff[1] | m_ff[2];
   assign prod_x = AW'(prod);
   assign diff  = acc_ff - prod_x;
   assign num   = {1'b0, a_sel, {tbn_pkg::A_W{1'b0}}} + tbn_pkg::NUM_W'(root >> 1);

   always_comb begin
      case (ci_ff)
         2'd0:    a_sel = m_ff[0][tbn_pkg::A_W-1:0];
         2'd1:    a_sel = m_ff[1][tbn_pkg::A_W-1:0];
         default: a_sel = m_ff[2][tbn_pkg::A_W-1:0];
      endcase
   end

   always_comb begin
      if (state_ff == tbn_pkg::S_SQR) begin
         op_a = DW'({1'b0, a_sel});
         op_b = DW'({1'b0, a_sel});
      end else begin
         case (mi_ff)
            4'd0:    begin op_a = du1_ff; op_b = dv2_ff;   end
            4'd1:    begin op_a = du2_ff; op_b = dv1_ff;   end
            4'd2:    begin op_a = dv2_ff; op_b = e1_ff[0]; end
            4'd3:    begin op_a = dv1_ff; op_b = e2_ff[0]; end
            4'd4:    begin op_a = dv2_ff; op_b = e1_ff[1]; end
            4'd5:    begin op_a = dv1_ff; op_b = e2_ff[1]; end
            4'd6:    begin op_a = dv2_ff; op_b = e1_ff[2]; end
            4'd7:    begin op_a = dv1_ff; op_b = e2_ff[2]; end
            4'd8:    begin op_a = du1_ff; op_b = e2_ff[0]; end
            4'd9:    begin op_a = du2_ff; op_b = e1_ff[0]; end
            4'd10:   begin op_a = du1_ff; op_b = e2_ff[1]; end
            4'd11:   begin op_a = du2_ff; op_b = e1_ff[1]; end
            4'd12:   begin op_a = du1_ff; op_b = e2_ff[2]; end
            4'd13:   begin op_a = du2_ff; op_b = e1_ff[2]; end
            default: begin op_a = '0;     op_b = '0;       end
         endcase
      end
   end

   tbn_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod)
   );

   assign rt_ctl.start = (state_ff == tbn_pkg::S_RT_GO);
   assign dv_ctl.start = (state_ff == tbn_pkg::S_DIV_GO);

   tbn_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (rt_ctl.start),
      .rad     (sum_ff),
      .root    (root),
      .done_ff (rt_ctl.done)
   );

   tbn_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (dv_ctl.start),
      .num     (num),
      .den     (root),
      .quo_ff  (quo),
      .done_ff (dv_ctl.done)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tbn_pkg::S_IDLE:     if (req_acc && slot == 2'd2) state_in = tbn_pkg::S_MUL;
         tbn_pkg::S_MUL:      state_in = tbn_pkg::S_ACC;
         tbn_pkg::S_ACC:      state_in = (mi_ff == 4'(tbn_pkg::MUL_LAST)) ?
                                         tbn_pkg::S_CHECK : tbn_pkg::S_MUL;
         tbn_pkg::S_CHECK:    state_in = (det_ff == '0) ? tbn_pkg::S_OUT : tbn_pkg::S_LOAD;
         tbn_pkg::S_LOAD:     state_in = tbn_pkg::S_NORM;
         tbn_pkg::S_NORM: begin
            if (m_or == '0) state_in = tbn_pkg::S_OUT;
            else if (m_or[MW-1:tbn_pkg::A_W] == '0 && m_or[tbn_pkg::A_W-1])
               state_in = tbn_pkg::S_SQR;
         end
         tbn_pkg::S_SQR:      state_in = tbn_pkg::S_SQA;
         tbn_pkg::S_SQA:      state_in = (ci_ff == 2'd2) ? tbn_pkg::S_RT_GO : tbn_pkg::S_SQR;
         tbn_pkg::S_RT_GO:    state_in = tbn_pkg::S_RT_WAIT;
         tbn_pkg::S_RT_WAIT:  if (rt_ctl.done) state_in = tbn_pkg::S_DIV_GO;
         tbn_pkg::S_DIV_GO:   state_in = tbn_pkg::S_DIV_WAIT;
         tbn_pkg::S_DIV_WAIT: begin
            if (dv_ctl.done) begin
               if (ci_ff != 2'd2)  state_in = tbn_pkg::S_DIV_GO;
               else if (!vsel_ff)  state_in = tbn_pkg::S_LOAD;
               else                state_in = tbn_pkg::S_OUT;
            end
         end
         tbn_pkg::S_OUT:      if (out_load) state_in = tbn_pkg::S_IDLE;
         default:             state_in = tbn_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tbn_pkg::S_IDLE;
         cnt_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         if (req_acc) cnt_ff <= (slot == 2'd2) ? 2'd0 : slot + 2'd1;
      end
   end

   // vertex hold and datapath
   always_ff @(posedge clock) begin
      if (req_acc && slot != 2'd2) begin
         for (int i = 0; i < 3; i++) hp_ff[slot[0]][i] <= pin[i];
         ht_ff[slot[0]][0] <= req_tex_u;
         ht_ff[slot[0]][1] <= req_tex_v;
      end
      if (req_acc && slot == 2'd2) begin
         for (int i = 0; i < 3; i++) begin
            e1_ff[i] <= DW'(hp_ff[1][i]) - DW'(hp_ff[0][i]);
            e2_ff[i] <= DW'(pin[i]) - DW'(hp_ff[0][i]);
         end
         du1_ff   <= DW'(ht_ff[1][0]) - DW'(ht_ff[0][0]);
         dv1_ff   <= DW'(ht_ff[1][1]) - DW'(ht_ff[0][1]);
         du2_ff   <= DW'(req_tex_u) - DW'(ht_ff[0][0]);
         dv2_ff   <= DW'(req_tex_v) - DW'(ht_ff[0][1]);
         mi_ff    <= '0;
         vsel_ff  <= 1'b0;
         degen_ff <= 1'b0;
      end
      case (state_ff)
         tbn_pkg::S_ACC: begin
            mi_ff <= mi_ff + 4'd1;
            if (!mi_ff[0]) begin
               acc_ff <= prod_x;
            end else begin
               case (mi_ff[3:1])
                  3'd0:    det_ff   <= diff;
                  3'd1:    tc_ff[0] <= diff;
                  3'd2:    tc_ff[1] <= diff;
                  3'd3:    tc_ff[2] <= diff;
                  3'd4:    bc_ff[0] <= diff;
                  3'd5:    bc_ff[1] <= diff;
                  default: bc_ff[2] <= diff;
               endcase
            end
         end
         tbn_pkg::S_CHECK: if (det_ff == '0) degen_ff <= 1'b1;
         tbn_pkg::S_LOAD: begin
            for (int i = 0; i < 3; i++) begin
               logic signed [AW-1:0] c;
               c = vsel_ff ? bc_ff[i] : tc_ff[i];
               m_ff[i] <= c[AW-1] ? MW'(-c) : MW'(c);
               sg_ff[vsel_ff][i] <= c[AW-1] ^ det_ff[AW-1];
            end
         end
         tbn_pkg::S_NORM: begin
            if (m_or == '0) begin
               degen_ff <= 1'b1;
            end else if (m_or[MW-1:tbn_pkg::A_W] != '0) begin
               for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] >> 1;
            end else if (!m_or[tbn_pkg::A_W-1]) begin
               for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] << 1;
            end else begin
               ci_ff  <= 2'd0;
               sum_ff <= '0;
            end
         end
         tbn_pkg::S_SQA: begin
            sum_ff <= sum_ff + prod[tbn_pkg::SUM_W-1:0];
            ci_ff  <= (ci_ff == 2'd2) ? 2'd0 : ci_ff + 2'd1;
         end
         tbn_pkg::S_DIV_WAIT: begin
            if (dv_ctl.done) begin
               qt_ff[vsel_ff][ci_ff] <= quo;
               if (ci_ff == 2'd2) begin
                  ci_ff   <= 2'd0;
                  vsel_ff <= 1'b1;
               end else begin
                  ci_ff <= ci_ff + 2'd1;
               end
            end
         end
         default: ;
      endcase
   end

   // result register
   assign out_load = (state_ff == tbn_pkg::S_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      for (int v = 0; v < 2; v++) begin
         for (int i = 0; i < 3; i++) begin
            if (degen_ff)          res[v][i] = '0;
            else if (sg_ff[v][i])  res[v][i] = -OW'(qt_ff[v][i]);
            else                   res[v][i] = OW'(qt_ff[v][i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         o_ff         <= res;
         rsp_degen_ff <= degen_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tangent_x   = o_ff[0][0];
   assign rsp_tangent_y   = o_ff[0][1];
   assign rsp_tangent_z   = o_ff[0][2];
   assign rsp_bitangent_x = o_ff[1][0];
   assign rsp_bitangent_y = o_ff[1][1];
   assign rsp_bitangent_z = o_ff[1][2];
   assign rsp_degenerate  = rsp_degen_ff;

endmodule

// ===== design/tbn_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbn_checker
// port-level checks of the tangent/bitangent unit
// ----------------------------------------------------------------------------
module tbn_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_tangent_x,
   input  logic signed [31:0] rsp_tangent_y,
   input  logic signed [31:0] rsp_tangent_z,
   input  logic signed [31:0] rsp_bitangent_x,
   input  logic signed [31:0] rsp_bitangent_y,
   input  logic signed [31:0] rsp_bitangent_z,
   input  logic               rsp_degenerate
);

   logic all_zero;
   logic in_range;

   assign all_zero = rsp_tangent_x == 0 && rsp_tangent_y == 0 && rsp_tangent_z == 0 &&
                     rsp_bitangent_x == 0 && rsp_bitangent_y == 0 && rsp_bitangent_z == 0;

   assign in_range =
      rsp_tangent_x   <= 32'sd1073741824 && rsp_tangent_x   >= -32'sd1073741824 &&
      rsp_tangent_y   <= 32'sd1073741824 && rsp_tangent_y   >= -32'sd1073741824 &&
      rsp_tangent_z   <= 32'sd1073741824 && rsp_tangent_z   >= -32'sd1073741824 &&
      rsp_bitangent_x <= 32'sd1073741824 && rsp_bitangent_x >= -32'sd1073741824 &&
      rsp_bitangent_y <= 32'sd1073741824 && rsp_bitangent_y >= -32'sd1073741824 &&
      rsp_bitangent_z <= 32'sd1073741824 && rsp_bitangent_z >= -32'sd1073741824;

   // stalled transfer holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tangent_x) &&
      $stable(rsp_bitangent_z) && $stable(rsp_degenerate))
      else $error("stalled result changed");

   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> all_zero)
      else $error("degenerate result with nonzero vector");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |-> in_range && !all_zero)
      else $error("unit vector out of range");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind triangle_tangent_bitangent tbn_checker u_tbn_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_tangent_x   (rsp_tangent_x),
   .rsp_tangent_y   (rsp_tangent_y),
   .rsp_tangent_z   (rsp_tangent_z),
   .rsp_bitangent_x (rsp_bitangent_x),
   .rsp_bitangent_y (rsp_bitangent_y),
   .rsp_bitangent_z (rsp_bitangent_z),
   .rsp_degenerate  (rsp_degenerate)
);
